FILE: sv/fscgs_pkg.sv
// Shared types, constants and the CV code function of the step sequencer.
package fscgs_pkg;

  localparam int VAL_W      = 6;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;
  localparam int IN_ITEM_W  = 5;
  localparam int RES_W      = 21;

  localparam logic [11:0] CV_MAX   = 12'd4095;
  localparam logic [15:0] CV_RECIP = 16'd34953;
  localparam logic [15:0] CV_BIAS  = 16'd7;

  typedef struct packed {
    logic              gate_b;
    logic              gate_a;
    logic              encoder_press;
    logic signed [1:0] encoder_delta;
  } in_item_t;

  typedef struct packed {
    logic        editing;
    logic [3:0]  cursor_slot;
    logic [2:0]  current_step;
    logic        gate_out;
    logic [11:0] cv_code;
  } res_t;

  // round(v * 1024 / 15) = floor((v * 1024 + 7) / 15), saturated
  function automatic logic [11:0] cv_of(input logic [VAL_W-1:0] v);
    logic [15:0] m;
    logic [31:0] p;
    logic [12:0] q;
    m = {v, 10'd0} + CV_BIAS;
    p = 32'(m) * 32'(CV_RECIP);
    q = p[31:19];
    return (q > 13'(CV_MAX)) ? CV_MAX : q[11:0];
  endfunction

endpackage

FILE: sv/five_step_cv_gate_sequencer_unit.sv
// Top level of the five-step CV/gate step sequencer.
// Each input word is one control scan: in_tdata carries the encoder delta,
// the encoder press edge and the two gate trigger edges. Each accepted word
// produces exactly one result word on the out_ channel with the DAC code of
// the playing step, the one-scan gate pulse, the playing step, the menu
// cursor and the edit flag, all as they stand after that scan.
// A word accepted into the input register passes through the scan logic into the
// output register when it is free, and is then presented on out_tvalid.
// Throughput: one word per cycle while the receiver keeps out_tready high;
// the scan update is one logic pass between the input and result registers.
// Reset (rst_n low, synchronous) clears all step values and trigger flags,
// the playing step, the cursor and edit mode, and empties both registers.
// When the receiver stalls, the result word holds in the output register,
// one more word waits in the input register, and in_tready then drops until
// out_tready returns.
module five_step_cv_gate_sequencer_unit #(
  parameter int NUM_STEPS    = 5,
  parameter int MAX_SEMITONE = 60
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [1:0] encoder_delta, [2] encoder_press, [3] gate_a, [4] gate_b, [7:5] zero
  input  logic [fscgs_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [11:0] cv_code, [12] gate_out, [15:13] current_step, [19:16] cursor_slot,
  // [20] editing, [23:21] zero
  output logic [fscgs_pkg::OUT_DATA_W-1:0] out_tdata
);
  import fscgs_pkg::*;

  logic     adv;
  logic     item_valid;
  logic     fire;
  in_item_t item;
  res_t     res;

  assign fire = item_valid && adv;

  fscgs_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  fscgs_core #(
    .NUM_STEPS    (NUM_STEPS),
    .MAX_SEMITONE (MAX_SEMITONE)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .res   (res)
  );

  fscgs_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .res        (res),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: sv/fscgs_in_stage.sv
// Input register stage: holds one accepted word until the core takes it.
module fscgs_in_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [fscgs_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                      adv,
  output logic                      item_valid,
  output fscgs_pkg::in_item_t       item
);
  import fscgs_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  assign in_tready = !valid_r || adv;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item_t'(in_tdata[IN_ITEM_W-1:0]);
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: sv/fscgs_core.sv
// Sequencer state and next-state logic: cursor, edit mode, step lanes, play step.
module fscgs_core #(
  parameter int NUM_STEPS    = 5,
  parameter int MAX_SEMITONE = 60
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  fscgs_pkg::in_item_t item,
  output fscgs_pkg::res_t     res
);
  import fscgs_pkg::*;

  localparam int SLOTS  = 2 * NUM_STEPS;
  localparam int CUR_W  = $clog2(SLOTS);
  localparam int STEP_W = $clog2(NUM_STEPS);
  localparam int SW     = CUR_W + 2;
  localparam int VW     = VAL_W + 2;

  logic [CUR_W-1:0]  cursor_r, cursor_nxt;
  logic              edit_r, edit_nxt;
  logic [STEP_W-1:0] play_r, play_nxt;
  logic [VAL_W-1:0]  val_r [NUM_STEPS];
  logic [VAL_W-1:0]  val_nxt [NUM_STEPS];
  logic              flag_r [NUM_STEPS];
  logic              flag_nxt [NUM_STEPS];

  logic signed [SW-1:0] cur_sum;
  logic signed [SW-1:0] cur_wrap;
  logic [CUR_W-1:0]     cur_browse;
  logic                 on_value;
  logic [CUR_W-1:0]     edit_idx;
  logic [CUR_W-1:0]     flag_idx;
  logic signed [VW-1:0] val_sum;
  logic [VAL_W-1:0]     play_val;
  logic                 gate;
  logic                 pulse;
  logic [STEP_W+2:0]    step_ext;
  logic [CUR_W+3:0]     cur_ext;

  assign gate = item.gate_a | item.gate_b;

  always_comb begin
    cur_sum = $signed({2'b00, cursor_r}) + SW'(item.encoder_delta);
    if (cur_sum < 0) begin
      cur_wrap = cur_sum + SW'(SLOTS);
    end else if (cur_sum >= SW'(SLOTS)) begin
      cur_wrap = cur_sum - SW'(SLOTS);
    end else begin
      cur_wrap = cur_sum;
    end
    cur_browse = cur_wrap[CUR_W-1:0];
    on_value   = cur_browse < CUR_W'(NUM_STEPS);
    edit_idx   = (cursor_r < CUR_W'(NUM_STEPS)) ? cursor_r : cursor_r - CUR_W'(NUM_STEPS);
    flag_idx   = cur_browse - CUR_W'(NUM_STEPS);
  end

  always_comb begin
    if (edit_r) begin
      cursor_nxt = cursor_r;
      edit_nxt   = !item.encoder_press;
    end else begin
      cursor_nxt = cur_browse;
      edit_nxt   = on_value && item.encoder_press;
    end
  end

  always_comb begin
    val_sum = '0;
    for (int i = 0; i < NUM_STEPS; i++) begin
      val_nxt[i]  = val_r[i];
      flag_nxt[i] = flag_r[i];
      if (edit_r && edit_idx == CUR_W'(i)) begin
        val_sum = $signed({2'b00, val_r[i]}) + VW'(item.encoder_delta);
        if (val_sum < 0) begin
          val_nxt[i] = '0;
        end else if (val_sum > VW'(MAX_SEMITONE)) begin
          val_nxt[i] = VAL_W'(MAX_SEMITONE);
        end else begin
          val_nxt[i] = val_sum[VAL_W-1:0];
        end
      end
      if (!edit_r && !on_value && item.encoder_press && flag_idx == CUR_W'(i)) begin
        flag_nxt[i] = !flag_r[i];
      end
    end
  end

  always_comb begin
    play_nxt = play_r;
    if (gate) begin
      play_nxt = (play_r == STEP_W'(NUM_STEPS - 1)) ? '0 : play_r + 1'b1;
    end
    pulse    = gate && flag_nxt[play_nxt];
    play_val = val_nxt[play_nxt];
  end

  always_comb begin
    step_ext         = {3'b000, play_nxt};
    cur_ext          = {4'b0000, cursor_nxt};
    res.cv_code      = cv_of(play_val);
    res.gate_out     = pulse;
    res.current_step = step_ext[2:0];
    res.cursor_slot  = cur_ext[3:0];
    res.editing      = edit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      edit_r   <= 1'b0;
      play_r   <= '0;
      for (int i = 0; i < NUM_STEPS; i++) begin
        val_r[i]  <= '0;
        flag_r[i] <= 1'b0;
      end
    end else if (fire) begin
      cursor_r <= cursor_nxt;
      edit_r   <= edit_nxt;
      play_r   <= play_nxt;
      for (int i = 0; i < NUM_STEPS; i++) begin
        val_r[i]  <= val_nxt[i];
        flag_r[i] <= flag_nxt[i];
      end
    end
  end

endmodule

FILE: sv/fscgs_out_stage.sv
// Result register: holds one result word until the receiver takes it.
module fscgs_out_stage (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             fire,
  input  fscgs_pkg::res_t                  res,
  output logic                             adv,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [fscgs_pkg::OUT_DATA_W-1:0] out_tdata
);
  import fscgs_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  assign adv = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (adv) begin
      valid_nxt = fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {(OUT_DATA_W - RES_W)'(0), res_r};

endmodule

FILE: tb/sv/five_step_cv_gate_sequencer_unit_checker.sv
// Scan predictor and result comparator for the five-step CV/gate sequencer.
`timescale 1ns / 100ps
module five_step_cv_gate_sequencer_unit_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [fscgs_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [fscgs_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                               mismatches,
  output int                               outstanding
);
  import fscgs_pkg::*;

  localparam int STEPS    = 5;
  localparam int TOP_SEMI = 60;
  localparam int SLOTS    = 2 * STEPS;
  localparam int DAC_TOP  = 4095;

  logic [VAL_W-1:0] semitone [STEPS];
  logic [STEPS-1:0] trig_flags;
  int unsigned      play_idx;
  int unsigned      menu_slot;
  bit               in_edit;
  res_t             scan_results [$];

  // round(v * 1024 / 15), saturated to the DAC range
  function automatic logic [11:0] dac_code(input logic [VAL_W-1:0] v);
    int c;
    c = (int'(v) * 1024 + 7) / 15;
    return (c > DAC_TOP) ? 12'(DAC_TOP) : 12'(c);
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  task automatic advance_scan(input in_item_t it);
    int   d;
    int   k;
    int   v;
    bit   pulse;
    res_t r;
    d = it.encoder_delta[1] ? int'(it.encoder_delta[1:0]) - 4 : int'(it.encoder_delta[1:0]);
    if (!in_edit) begin
      menu_slot = (int'(menu_slot) + d + SLOTS) % SLOTS;
      if (menu_slot < STEPS) begin
        in_edit = it.encoder_press;
      end else if (it.encoder_press) begin
        trig_flags[menu_slot - STEPS] = ~trig_flags[menu_slot - STEPS];
      end
    end else begin
      k = (menu_slot < STEPS) ? menu_slot : menu_slot - STEPS;
      v = int'(semitone[k]) + d;
      if (v < 0) v = 0;
      if (v > TOP_SEMI) v = TOP_SEMI;
      semitone[k] = VAL_W'(v);
      in_edit = !it.encoder_press;
    end
    pulse = 1'b0;
    if (it.gate_a || it.gate_b) begin
      play_idx = (play_idx + 1) % STEPS;
      pulse = trig_flags[play_idx];
    end
    r.cv_code      = dac_code(semitone[play_idx]);
    r.gate_out     = pulse;
    r.current_step = 3'(play_idx);
    r.cursor_slot  = 4'(menu_slot);
    r.editing      = in_edit;
    scan_results.push_back(r);
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      for (int i = 0; i < STEPS; i++) semitone[i] = '0;
      trig_flags = '0;
      play_idx   = 0;
      menu_slot  = 0;
      in_edit    = 1'b0;
      scan_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[RES_W-1:0]);
        if (scan_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected word, expected none, actual %h", $time, out_tdata);
        end else begin
          want = scan_results.pop_front();
          check_field("cv_code", want.cv_code, got.cv_code);
          check_field("gate_out", want.gate_out, got.gate_out);
          check_field("current_step", want.current_step, got.current_step);
          check_field("cursor_slot", want.cursor_slot, got.cursor_slot);
          check_field("editing", want.editing, got.editing);
          check_field("pad", 0, int'(out_tdata[OUT_DATA_W-1:RES_W]));
        end
      end
      if (in_tvalid && in_tready) advance_scan(in_item_t'(in_tdata[IN_ITEM_W-1:0]));
    end
    outstanding = scan_results.size();
  end

endmodule

FILE: tb/sv/five_step_cv_gate_sequencer_unit_test.sv
// Stimulus, flow control and verdict for the five-step CV/gate sequencer.
`timescale 1ns / 100ps
module five_step_cv_gate_sequencer_unit_test;
  import fscgs_pkg::*;

  localparam logic [1:0] DELTA_NONE  = 2'b00;
  localparam logic [1:0] DELTA_UP    = 2'b01;
  localparam logic [1:0] DELTA_DOWN2 = 2'b10;
  localparam logic [1:0] DELTA_DOWN  = 2'b11;
  localparam int SEGMENTS  = 8;
  localparam int SEG_SCANS = 238;
  localparam int HOLD_CYC  = 300;
  localparam int LIMIT     = 200000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // [1:0] encoder_delta, [2] encoder_press, [3] gate_a, [4] gate_b, [7:5] zero
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [11:0] cv_code, [12] gate_out, [15:13] current_step, [19:16] cursor_slot,
  // [20] editing, [23:21] zero
  logic [OUT_DATA_W-1:0] out_tdata;

  int mismatches;
  int outstanding;
  int sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int cycles = 0;

  five_step_cv_gate_sequencer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  five_step_cv_gate_sequencer_unit_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("five_step_cv_gate_sequencer_unit_test: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYC;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic bit coin(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [IN_DATA_W-1:0] scan_word(input logic [1:0] delta,
                                                     input bit press, input bit ga,
                                                     input bit gb);
    in_item_t it;
    it.encoder_delta = delta;
    it.encoder_press = press;
    it.gate_a        = ga;
    it.gate_b        = gb;
    return IN_DATA_W'(it);
  endfunction

  task automatic send_scan(input logic [IN_DATA_W-1:0] w);
    while (coin(idle_pct)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic noise_run;
    int n;
    n = $urandom_range(1, 20);
    repeat (n) send_scan(scan_word(2'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)));
  endtask

  // seek a slot, press, sweep the value mostly one way, press to leave
  task automatic edit_run;
    int         n;
    bit         up;
    logic [1:0] toward;
    n = $urandom_range(0, 3);
    repeat (n) send_scan(scan_word(coin(50) ? DELTA_UP : DELTA_DOWN, 1'b0, coin(15), coin(15)));
    send_scan(scan_word(DELTA_NONE, 1'b1, coin(15), coin(15)));
    n  = $urandom_range(1, 80);
    up = coin(50);
    repeat (n) begin
      if (up) toward = DELTA_UP;
      else toward = coin(50) ? DELTA_DOWN : DELTA_DOWN2;
      send_scan(scan_word(coin(80) ? toward : 2'($urandom), 1'b0, coin(20), coin(20)));
    end
    send_scan(scan_word(2'($urandom), 1'b1, coin(30), coin(30)));
  endtask

  task automatic flag_run;
    int n;
    n = $urandom_range(1, 6);
    repeat (n) send_scan(scan_word(2'($urandom), coin(50), coin(50), coin(50)));
  endtask

  initial begin
    int seg_end;
    int phase;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_scan(scan_word(DELTA_NONE, 1'b0, 1'b0, 1'b0));
    send_scan(scan_word(DELTA_DOWN2, 1'b0, 1'b0, 1'b0));
    send_scan(scan_word(DELTA_UP, 1'b0, 1'b0, 1'b0));
    send_scan(scan_word(DELTA_UP, 1'b0, 1'b0, 1'b0));
    send_scan(scan_word(DELTA_DOWN, 1'b0, 1'b0, 1'b0));
    send_scan(scan_word(DELTA_NONE, 1'b1, 1'b0, 1'b0));
    send_scan(scan_word(DELTA_NONE, 1'b0, 1'b1, 1'b0));
    send_scan(scan_word(DELTA_NONE, 1'b0, 1'b0, 1'b1));
    send_scan(scan_word(DELTA_NONE, 1'b0, 1'b1, 1'b1));
    send_scan(scan_word(DELTA_NONE, 1'b0, 1'b1, 1'b0));
    send_scan(scan_word(DELTA_NONE, 1'b0, 1'b0, 1'b1));
    send_scan(scan_word(DELTA_UP, 1'b0, 1'b0, 1'b0));
    send_scan(scan_word(DELTA_NONE, 1'b1, 1'b0, 1'b0));
    send_scan(scan_word(DELTA_DOWN2, 1'b0, 1'b0, 1'b0));
    send_scan(scan_word(DELTA_UP, 1'b0, 1'b0, 1'b0));
    send_scan(scan_word(DELTA_UP, 1'b0, 1'b0, 1'b0));
    send_scan(scan_word(DELTA_DOWN, 1'b1, 1'b0, 1'b0));
    send_scan(scan_word(DELTA_DOWN2, 1'b1, 1'b0, 1'b0));
    send_scan(scan_word(DELTA_DOWN, 1'b1, 1'b1, 1'b1));
    send_scan(scan_word(DELTA_UP, 1'b1, 1'b1, 1'b1));
    send_scan(scan_word(DELTA_NONE, 1'b1, 1'b0, 1'b0));
    drain();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      phase     = seg % 4;
      idle_pct  = (phase == 1) ? 50 : (phase == 3) ? 13 : 0;
      stall_pct <= (phase == 2) ? 50 : (phase == 3) ? 13 : 0;
      if (seg == 2) hold_req <= 1'b1;
      seg_end = sent + SEG_SCANS;
      while (sent < seg_end) begin
        case ($urandom_range(3))
          0: noise_run();
          3: flag_run();
          default: edit_run();
        endcase
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("five_step_cv_gate_sequencer_unit_test: PASS");
    end else begin
      $display("five_step_cv_gate_sequencer_unit_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: five_step_cv_gate_sequencer_unit.f
sv/fscgs_pkg.sv
sv/fscgs_in_stage.sv
sv/fscgs_core.sv
sv/fscgs_out_stage.sv
sv/five_step_cv_gate_sequencer_unit.sv
tb/sv/five_step_cv_gate_sequencer_unit_checker.sv
tb/sv/five_step_cv_gate_sequencer_unit_test.sv
